### rtl/x86_16_instruction_length_decoder_defines.svh
// ----------------------------------------------------------------------------
// x86_16_instruction_length_decoder_defines
// assertion macros shared by the instruction length decoder rtl
// ----------------------------------------------------------------------------
`ifndef X86_16_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH
`define X86_16_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define X86IL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("x86il assertion failed");

// consequent must hold in the cycle after the antecedent
`define X86IL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("x86il assertion failed");

`else

`define X86IL_ASSERT_NOW(lbl, ante, cons)
`define X86IL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/x86il_pkg.sv
// ----------------------------------------------------------------------------
// x86il_pkg
// types, status codes and opcode tables for the 8086 instruction framer
// ----------------------------------------------------------------------------
package x86il_pkg;

  localparam int unsigned MaxBytes  = 6;
  localparam int unsigned BytesW    = 8 * MaxBytes;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TRUNCATED   = 2'd3
  } status_t;

  // opcode class: modrm form, unsupported, or fixed length
  typedef struct packed {
    logic       modrm;
    logic       unsup;
    logic [2:0] len;
  } op_class_t;

  typedef struct packed {
    logic [BytesW-1:0] bytes;
    logic [2:0]        seen;
    logic [2:0]        needed;
    logic              awaiting;
    logic [7:0]        opcode;
  } frame_state_t;

  typedef struct packed {
    status_t           status;
    logic [2:0]        len;
    logic [BytesW-1:0] bytes;
  } frame_res_t;

  typedef struct packed {
    logic       emit;
    frame_res_t res;
  } frame_out_t;

  function automatic op_class_t classify(input logic [7:0] op);
    op_class_t c;
    logic      one;
    c   = '0;
    one = 1'b0;
    case (op)
      8'h27, 8'h2F, 8'h37, 8'h3F, 8'h98, 8'h99, 8'h9B,
      8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF,
      8'hC3, 8'hCB, 8'hCC, 8'hCE, 8'hCF,
      8'hF0, 8'hF2, 8'hF3, 8'hF4, 8'hF5,
      8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD: one = 1'b1;
      default: one = 1'b0;
    endcase
    if (one || op[7:4] == 4'h4) begin
      c.len = 3'd1;
    end else if (op == 8'hEA || op == 8'h9A) begin
      c.len = 3'd5;
    end else if (op == 8'hCD || op == 8'hEB || op[7:4] == 4'h7 ||
                 (op & 8'hFC) == 8'hE0) begin
      c.len = 3'd2;
    end else if (op == 8'hFF || op == 8'hF6 || op == 8'hF7 ||
                 (op & 8'hFC) == 8'hD0 || (op & 8'hFC) == 8'h80 ||
                 op == 8'h84 || op == 8'h85 || (op < 8'h40 && !op[2])) begin
      c.modrm = 1'b1;
    end else if ((op & 8'hFE) == 8'hE8) begin
      c.len = 3'd3;
    end else if ((op < 8'h40 && op[2:1] == 2'b10) || (op & 8'hFE) == 8'hA8) begin
      c.len = op[0] ? 3'd3 : 3'd2;
    end else if ((op & 8'hF8) == 8'hD8) begin
      c.modrm = 1'b1;
    end else if ((op & 8'hF7) == 8'hC2) begin
      c.len = 3'd3;
    end else begin
      c.unsup = 1'b1;
    end
    return c;
  endfunction

  function automatic logic modrm_invalid(input logic [7:0] op, input logic [2:0] rg);
    logic bad;
    bad = 1'b0;
    if (op == 8'hFF) begin
      bad = (rg == 3'd6) || (rg == 3'd7);
    end else if ((op & 8'hFC) == 8'hD0) begin
      bad = (rg == 3'd6);
    end else if (op == 8'hF6 || op == 8'hF7) begin
      bad = (rg == 3'd1);
    end
    return bad;
  endfunction

  function automatic logic [1:0] imm_len(input logic [7:0] op, input logic [2:0] rg);
    logic [1:0] n;
    n = 2'd0;
    if (op == 8'h81) begin
      n = 2'd2;
    end else if ((op & 8'hFC) == 8'h80) begin
      n = 2'd1;
    end else if (op == 8'hF6 && rg == 3'd0) begin
      n = 2'd1;
    end else if (op == 8'hF7 && rg == 3'd0) begin
      n = 2'd2;
    end
    return n;
  endfunction

  function automatic logic [1:0] disp_len(input logic [7:0] m);
    logic [1:0] n;
    n = 2'd0;
    if (m[7:6] == 2'b01) begin
      n = 2'd1;
    end else if (m[7:6] == 2'b10) begin
      n = 2'd2;
    end else if (m[7:6] == 2'b00 && m[2:0] == 3'b110) begin
      n = 2'd2;
    end
    return n;
  endfunction

endpackage

### rtl/x86_16_instruction_length_decoder.sv
// ----------------------------------------------------------------------------
// x86_16_instruction_length_decoder
// frames a 16-bit x86 code stream into instructions, one byte per item
// ----------------------------------------------------------------------------
// One code byte is taken per clock while the skid register is empty. The
// framing state updates in the cycle the byte is accepted; the finished
// instruction (bytes, length 1..6, status) goes to the result register, or to
// the skid register while the result register waits. This two-entry output
// buffer lets input continue while a result waits; the input stalls only
// when both entries hold results that the sink has not taken.
`include "x86_16_instruction_length_decoder_defines.svh"

module x86_16_instruction_length_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // code_byte[7:0]
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // instr_bytes[47:0], instr_length[50:48], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  x86il_pkg::frame_state_t state_r, state_nxt;
  x86il_pkg::frame_out_t   dec_out;
  x86il_pkg::frame_res_t   out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic in_fire, out_fire, main_free;

  x86il_frame_dec u_dec (
    .cur_state  (state_r),
    .code_byte  (in_tdata),
    .stream_end (in_tlast),
    .nxt_state  (state_nxt),
    .dec_out    (dec_out)
  );

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign main_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (skid_valid_r) begin
        if (out_fire) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire && dec_out.emit) begin
        if (main_free) begin
          out_r       <= dec_out.res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= dec_out.res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.len, out_r.bytes};
  assign out_tuser  = out_r.status;

  `X86IL_ASSERT_NOW(a_skid_implies_main, skid_valid_r, out_valid_r)
  `X86IL_ASSERT_NOW(a_awaiting_one_byte, state_r.awaiting, state_r.seen == 3'd1)
  `X86IL_ASSERT_NOW(a_needed_ahead, state_r.needed != 3'd0, state_r.seen < state_r.needed)
  `X86IL_ASSERT_NEXT(a_stall_to_skid, in_fire && dec_out.emit && out_valid_r && !out_tready, skid_valid_r)

endmodule

### rtl/x86il_frame_dec.sv
// ----------------------------------------------------------------------------
// x86il_frame_dec
// next-state and result logic for one code byte of the framer
// ----------------------------------------------------------------------------
module x86il_frame_dec (
  input  x86il_pkg::frame_state_t cur_state,
  input  logic [7:0]              code_byte,
  input  logic                    stream_end,
  output x86il_pkg::frame_state_t nxt_state,
  output x86il_pkg::frame_out_t   dec_out
);

  x86il_pkg::op_class_t cls;
  x86il_pkg::frame_state_t st;
  x86il_pkg::status_t status;
  logic       start;
  logic       emit;
  logic [2:0] rg;

  assign start = (cur_state.seen == 3'd0) || (cur_state.seen >= 3'(x86il_pkg::MaxBytes));
  assign cls   = x86il_pkg::classify(code_byte);
  assign rg    = code_byte[5:3];

  always_comb begin
    st     = cur_state;
    emit   = 1'b0;
    status = x86il_pkg::ST_OK;
    if (start) begin
      st.opcode   = code_byte;
      st.bytes    = {{(x86il_pkg::BytesW-8){1'b0}}, code_byte};
      st.seen     = 3'd1;
      st.awaiting = cls.modrm;
      st.needed   = (cls.modrm || cls.unsup) ? 3'd0 : cls.len;
      if (cls.unsup) begin
        emit   = 1'b1;
        status = x86il_pkg::ST_UNSUPPORTED;
      end else if (!cls.modrm && cls.len == 3'd1) begin
        emit = 1'b1;
      end
    end else begin
      // octets above seen are still zero, so a plain write equals the or
      st.bytes[{cur_state.seen, 3'b000} +: 8] = code_byte;
      st.seen = cur_state.seen + 3'd1;
      if (cur_state.awaiting) begin
        st.awaiting = 1'b0;
        if (x86il_pkg::modrm_invalid(cur_state.opcode, rg)) begin
          emit   = 1'b1;
          status = x86il_pkg::ST_INVALID;
        end else begin
          st.needed = 3'd2 + {1'b0, x86il_pkg::disp_len(code_byte)}
                    + {1'b0, x86il_pkg::imm_len(cur_state.opcode, rg)};
        end
      end
      if (!emit && st.needed != 3'd0 && st.seen >= st.needed) begin
        emit = 1'b1;
      end
    end
    if (!emit && stream_end) begin
      emit   = 1'b1;
      status = x86il_pkg::ST_TRUNCATED;
    end
  end

  assign dec_out.emit       = emit;
  assign dec_out.res.status = status;
  assign dec_out.res.len    = st.seen;
  assign dec_out.res.bytes  = st.bytes;
  assign nxt_state          = emit ? '0 : st;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// byte-stream test of the 8086 instruction length decoder: a scoreboard frames
// the same code bytes as the decoder and compares every emitted instruction
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FormUnsup   = 0;
  localparam int FormModrm   = 7;
  localparam int RandomItems = 1300;
  localparam int LimitCycles = 200_000;
  localparam int DrainCycles = 8;

  // directed bytes, bit 8 is the end-of-stream flag
  localparam logic [8:0] Directed [24] = '{
    9'h000, 9'h0C0,                                 // lowest byte, register form
    9'h0FF, 9'h0FF,                                 // ff with reg 7
    9'h081, 9'h080, 9'h011, 9'h022, 9'h033, 9'h044, // longest form
    9'h0D0, 9'h030,                                 // shift with reg 6
    9'h0F7, 9'h008,                                 // f7 with reg 1
    9'h086,                                         // unsupported
    9'h0EA, 9'h112,                                 // far jump cut by stream end
    9'h140,                                         // complete on the last byte
    9'h190,                                         // unsupported on the last byte
    9'h0F6, 9'h006, 9'h034, 9'h012, 9'h05A          // direct address plus imm8
  };

  typedef struct {
    logic [47:0]         bytes;
    logic [2:0]          len;
    x86il_pkg::status_t  status;
  } frame_t;

  class frame_scoreboard;
    bit [47:0]   acc;
    int unsigned cnt;
    int unsigned need;
    bit          want_modrm;
    bit [7:0]    first_op;
    frame_t      frames_due[$];
    int          errors;

    function new();
      acc = '0;
      cnt = 0;
      need = 0;
      want_modrm = 1'b0;
      first_op = '0;
      errors = 0;
    endfunction

    // fixed length 1..5, or a modrm form, or unsupported
    function int op_form(bit [7:0] op);
      int form;
      form = FormUnsup;
      case (op[7:6])
        2'b00: begin
          if (!op[2]) begin
            form = FormModrm;
          end else if (!op[1]) begin
            form = op[0] ? 3 : 2;
          end else if (op[5] && op[0]) begin
            form = 1;
          end
        end
        2'b01: begin
          if (op[5:4] == 2'b00) begin
            form = 1;
          end else if (op[5:4] == 2'b11) begin
            form = 2;
          end
        end
        2'b10: begin
          case (op)
            8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85: form = FormModrm;
            8'h98, 8'h99, 8'h9B, 8'hA4, 8'hA5, 8'hA6, 8'hA7,
            8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF: form = 1;
            8'h9A: form = 5;
            8'hA8: form = 2;
            8'hA9: form = 3;
            default: form = FormUnsup;
          endcase
        end
        default: begin
          case (op)
            8'hC2, 8'hCA, 8'hE8, 8'hE9: form = 3;
            8'hC3, 8'hCB, 8'hCC, 8'hCE, 8'hCF, 8'hF0, 8'hF2, 8'hF3, 8'hF4,
            8'hF5, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD: form = 1;
            8'hCD, 8'hEB, 8'hE0, 8'hE1, 8'hE2, 8'hE3: form = 2;
            8'hEA: form = 5;
            8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hD8, 8'hD9, 8'hDA, 8'hDB,
            8'hDC, 8'hDD, 8'hDE, 8'hDF, 8'hF6, 8'hF7, 8'hFF: form = FormModrm;
            default: form = FormUnsup;
          endcase
        end
      endcase
      return form;
    endfunction

    function bit modrm_bad(bit [7:0] op, bit [2:0] rg);
      if (op == 8'hFF) return rg >= 3'd6;
      if (op[7:2] == 6'b110100) return rg == 3'd6;
      if (op == 8'hF6 || op == 8'hF7) return rg == 3'd1;
      return 1'b0;
    endfunction

    function int disp_bytes(bit [7:0] m);
      case (m[7:6])
        2'b01: return 1;
        2'b10: return 2;
        2'b00: return (m[2:0] == 3'b110) ? 2 : 0;
        default: return 0;
      endcase
    endfunction

    function int imm_bytes(bit [7:0] op, bit [2:0] rg);
      if (op == 8'h81) return 2;
      if (op[7:2] == 6'b100000) return 1;
      if (op == 8'hF6 && rg == 3'd0) return 1;
      if (op == 8'hF7 && rg == 3'd0) return 2;
      return 0;
    endfunction

    // frame length a well-formed instruction takes, given its first two bytes
    function int instr_size(bit [7:0] op, bit [7:0] m);
      int form;
      form = op_form(op);
      if (form != FormModrm) return form;
      if (modrm_bad(op, m[5:3])) return 2;
      return 2 + disp_bytes(m) + imm_bytes(op, m[5:3]);
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task note_byte(bit [7:0] b, bit last);
      bit                 done;
      x86il_pkg::status_t st;
      int                 form;
      frame_t             f;
      done = 1'b0;
      st = x86il_pkg::ST_OK;
      if (cnt == 0) begin
        form = op_form(b);
        first_op = b;
        acc = {40'd0, b};
        cnt = 1;
        if (form == FormUnsup) begin
          done = 1'b1;
          st = x86il_pkg::ST_UNSUPPORTED;
        end else if (form == FormModrm) begin
          want_modrm = 1'b1;
        end else begin
          need = form;
          done = (form == 1);
        end
      end else begin
        acc[8*cnt +: 8] = b;
        cnt++;
        if (want_modrm) begin
          want_modrm = 1'b0;
          if (modrm_bad(first_op, b[5:3])) begin
            done = 1'b1;
            st = x86il_pkg::ST_INVALID;
          end else begin
            need = 2 + disp_bytes(b) + imm_bytes(first_op, b[5:3]);
          end
        end
        if (!done && need != 0 && cnt >= need) done = 1'b1;
      end
      if (!done && last) begin
        done = 1'b1;
        st = x86il_pkg::ST_TRUNCATED;
      end
      if (done) begin
        f.bytes = acc;
        f.len = 3'(cnt);
        f.status = st;
        frames_due.push_back(f);
        acc = '0;
        cnt = 0;
        need = 0;
        want_modrm = 1'b0;
        first_op = '0;
      end
    endtask

    task check_frame(logic [47:0] bytes, logic [2:0] len, x86il_pkg::status_t st);
      frame_t f;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame len %0d bytes %h", len, bytes));
        return;
      end
      f = frames_due.pop_front();
      if (bytes !== f.bytes)
        report_mismatch($sformatf("bytes %h, want %h", bytes, f.bytes));
      if (len !== f.len)
        report_mismatch($sformatf("length %0d, want %0d (bytes %h)", len, f.len, f.bytes));
      if (st !== f.status)
        report_mismatch($sformatf("status %s, want %s (bytes %h)",
                                  st.name(), f.status.name(), f.bytes));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  frame_scoreboard sb;
  int          in_idle_pct;
  int          out_idle_pct;
  int          bytes_sent;
  int unsigned cycles;

  x86_16_instruction_length_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_frame(out_tdata[47:0], out_tdata[50:48], x86il_pkg::status_t'(out_tuser));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(bit [7:0] b, bit last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // mostly whole instructions with random operands, some stray bytes,
  // and now and then a stream end inside an instruction
  task automatic send_random_instr();
    bit [7:0] seq [6];
    int       total;
    int       cut;
    if ($urandom_range(99) < 10) begin
      send_byte(8'($urandom_range(255)), $urandom_range(99) < 5);
      return;
    end
    do seq[0] = 8'($urandom_range(255)); while (sb.op_form(seq[0]) == FormUnsup);
    for (int i = 1; i < 6; i++) seq[i] = 8'($urandom_range(255));
    total = sb.instr_size(seq[0], seq[1]);
    cut = ($urandom_range(99) < 6) ? $urandom_range(total, 1) : 0;
    for (int i = 0; i < total; i++) begin
      send_byte(seq[i], (i + 1) == cut);
      if ((i + 1) == cut) break;
    end
  endtask

  task automatic wait_frames_out();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    bit drained;
    sb = new();
    drained = 1'b0;
    bytes_sent = 0;
    cycles = 0;
    in_idle_pct = 21;
    out_idle_pct = 48;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin in_idle_pct = 21; out_idle_pct = 48; end
        1: begin in_idle_pct = 48; out_idle_pct = 21; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      if (ph == 0) begin
        foreach (Directed[i]) send_byte(Directed[i][7:0], Directed[i][8]);
      end
      while (bytes_sent < (ph + 1) * RandomItems / 3) begin
        send_random_instr();
        if (ph == 0 && !drained && bytes_sent > 200) begin
          wait_frames_out();
          drained = 1'b1;
        end
      end
    end

    wait_frames_out();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
